>>> rtl/hrtp_pkg.sv
// Shared types and constants of the hex record text parser.
// Holds field widths, result kinds and the result struct; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hrtp_pkg;

    // address and count widths of the parser
    localparam int ADDR_BITS  = 32;
    localparam int COUNT_BITS = 16;
    localparam int SIZE_BITS  = ADDR_BITS + 1;
    localparam int CHAR_BITS  = 8;
    localparam int KIND_BITS  = 3;

    // output tdata: address, data byte, image size, padded to whole bytes
    localparam int OUT_PAYLOAD_W = ADDR_BITS + CHAR_BITS + SIZE_BITS;
    localparam int OUT_TDATA_W   = ((OUT_PAYLOAD_W + 7) / 8) * 8;

    // result kinds
    localparam logic [KIND_BITS-1:0] K_WRITE    = 3'd0;
    localparam logic [KIND_BITS-1:0] K_DONE     = 3'd1;
    localparam logic [KIND_BITS-1:0] K_BADHEX   = 3'd2;
    localparam logic [KIND_BITS-1:0] K_EMPTY    = 3'd3;
    localparam logic [KIND_BITS-1:0] K_OVERFLOW = 3'd4;

    // one result from the parser to the output register
    typedef struct packed {
        logic                  valid;
        logic [KIND_BITS-1:0]  kind;
        logic [ADDR_BITS-1:0]  address;
        logic [CHAR_BITS-1:0]  data;
        logic [SIZE_BITS-1:0]  size;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/hex_record_text_parser_core.sv
// Top level of the hex record text parser: stream ports, input and result registers.
// Depends on hrtp_pkg and hrtp_parse.
//
// Use: the update text enters on the s_axis side one character per request,
// s_axis_tdata[7:0] holding the character; s_axis_tlast marks the end-of-text
// request, whose character is ignored. Results leave on the m_axis side:
// m_axis_tuser carries the kind (byte write, image done, bad hex, empty image,
// count overflow) and m_axis_tdata the address, data byte and image size.
// A character passes through the input register and then, when the parser steps,
// into the result register; the step waits while the result register is full and
// m_axis_tready is low. Throughput: one character per clock, set by the parser step,
// while the result register is empty or m_axis_tready is high. A character that
// yields no result is still consumed at that rate.
// Reset (synchronous, i_rst_n low) empties both registers and returns the
// parser to line start with an empty image. When the receiver holds
// m_axis_tready low, the result register holds and the input register fills;
// s_axis_tready then drops until the result is taken. After a bad hex or count
// overflow report the parser ignores text until the next end-of-text request.
`timescale 1ns / 1ps
`default_nettype none

module hex_record_text_parser_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [7:0]                         s_axis_tdata,  // [7:0] text_char
    input  wire logic                               s_axis_tlast,  // end_of_text
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [31:0] write_address, [39:32] write_data, [72:40] image_size, rest zero
    output logic [hrtp_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    output logic [hrtp_pkg::KIND_BITS-1:0]          m_axis_tuser   // [2:0] kind
);

    logic                              r_in_valid;
    logic [hrtp_pkg::CHAR_BITS-1:0]    r_in_char;
    logic                              r_in_last;
    hrtp_pkg::t_result                 r_out;
    hrtp_pkg::t_result                 n_out;
    hrtp_pkg::t_result                 parse_res;
    logic                              out_free;
    logic                              step;

    // handshake: parser steps when the result slot is free or being emptied
    assign out_free      = !r_out.valid || m_axis_tready;
    assign step          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || step;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_char <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    hrtp_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_char   (r_in_char),
        .i_end    (r_in_last),
        .o_result (parse_res)
    );

    // next result: only a stepped character may raise valid
    always_comb begin
        n_out       = parse_res;
        n_out.valid = step && parse_res.valid;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out <= '0;
        end else if (out_free) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out.valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = {{(hrtp_pkg::OUT_TDATA_W-hrtp_pkg::OUT_PAYLOAD_W){1'b0}},
                            r_out.size, r_out.data, r_out.address};

endmodule

`default_nettype wire

>>> rtl/hrtp_parse.sv
// Line parser state machine of the hex record text parser.
// Holds all parse state and forms at most one result per character; uses hrtp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hrtp_parse (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_step,
    input  wire logic [hrtp_pkg::CHAR_BITS-1:0] i_char,
    input  wire logic                          i_end,
    output hrtp_pkg::t_result                  o_result
);

    typedef enum logic [3:0] {
        PH_START,
        PH_GOT_D,
        PH_ADDR,
        PH_SCAN,
        PH_COUNT,
        PH_FIRST,
        PH_HIGH,
        PH_LOW,
        PH_SKIP,
        PH_HALT
    } t_phase;

    localparam logic [hrtp_pkg::CHAR_BITS-1:0] CH_D     = 8'h44;
    localparam logic [hrtp_pkg::CHAR_BITS-1:0] CH_COLON = 8'h3A;
    localparam logic [hrtp_pkg::CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
    localparam logic [hrtp_pkg::CHAR_BITS-1:0] CH_NL    = 8'h0A;
    localparam int                             CV_W     = hrtp_pkg::COUNT_BITS + 4;
    localparam logic [hrtp_pkg::ADDR_BITS-1:0]  ADDR_ONE  = 1;
    localparam logic [hrtp_pkg::COUNT_BITS-1:0] COUNT_ONE = 1;

    t_phase                              r_phase, n_phase;
    logic [hrtp_pkg::ADDR_BITS-1:0]      r_line_address, n_line_address;
    logic [hrtp_pkg::COUNT_BITS-1:0]     r_byte_count, n_byte_count;
    logic [hrtp_pkg::COUNT_BITS-1:0]     r_bytes_left, n_bytes_left;
    logic [3:0]                          r_high_nibble, n_high_nibble;
    logic [hrtp_pkg::ADDR_BITS-1:0]      r_write_pointer, n_write_pointer;
    logic [hrtp_pkg::SIZE_BITS-1:0]      r_highest_end, n_highest_end;
    logic                                r_anything, n_anything;

    logic                                hex_ok;
    logic [3:0]                          hex_val;
    logic                                is_digit;
    logic [CV_W-1:0]                     count_next;
    logic [hrtp_pkg::SIZE_BITS-1:0]      line_end;
    logic [hrtp_pkg::ADDR_BITS-1:0]      wp_used;
    logic [hrtp_pkg::COUNT_BITS-1:0]     left_used;
    logic [hrtp_pkg::COUNT_BITS-1:0]     left_dec;

    // hex digit decode, both letter cases
    always_comb begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (i_char >= 8'h30 && i_char <= 8'h39) begin
            hex_val = i_char[3:0];
        end else if ((i_char >= 8'h61 && i_char <= 8'h66) ||
                     (i_char >= 8'h41 && i_char <= 8'h46)) begin
            hex_val = i_char[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign is_digit = (i_char >= 8'h30) && (i_char <= 8'h39);

    // count * 10 + digit as shift-add; top four bits flag overflow
    assign count_next = {1'b0, r_byte_count, 3'b000} + {3'b000, r_byte_count, 1'b0}
                      + {{(CV_W-4){1'b0}}, i_char[3:0]};

    assign line_end = {1'b0, r_line_address}
                    + {{(hrtp_pkg::SIZE_BITS-hrtp_pkg::COUNT_BITS){1'b0}}, r_byte_count};

    // first data character loads pointer and count before the low-digit step
    assign wp_used   = (r_phase == PH_FIRST) ? r_line_address : r_write_pointer;
    assign left_used = (r_phase == PH_FIRST) ? r_byte_count : r_bytes_left;
    assign left_dec  = (left_used != '0) ? left_used - COUNT_ONE : left_used;

    // next state and result
    always_comb begin
        n_phase         = r_phase;
        n_line_address  = r_line_address;
        n_byte_count    = r_byte_count;
        n_bytes_left    = r_bytes_left;
        n_high_nibble   = r_high_nibble;
        n_write_pointer = r_write_pointer;
        n_highest_end   = r_highest_end;
        n_anything      = r_anything;
        o_result        = '0;

        if (i_end) begin
            // end of text: report unless halted, then restart
            if (r_phase != PH_HALT) begin
                o_result.valid = 1'b1;
                if (r_anything) begin
                    o_result.kind = hrtp_pkg::K_DONE;
                    o_result.size = r_highest_end;
                end else begin
                    o_result.kind = hrtp_pkg::K_EMPTY;
                end
            end
            n_phase         = PH_START;
            n_line_address  = '0;
            n_byte_count    = '0;
            n_bytes_left    = '0;
            n_high_nibble   = '0;
            n_write_pointer = '0;
            n_highest_end   = '0;
            n_anything      = 1'b0;
        end else begin
            case (r_phase)
                PH_START: begin
                    if (i_char == CH_D) begin
                        n_phase = PH_GOT_D;
                    end else if (i_char == CH_PLUS) begin
                        n_phase = PH_SCAN;
                    end else if (i_char != CH_NL) begin
                        n_phase = PH_SKIP;
                    end
                end
                PH_GOT_D: begin
                    if (i_char == CH_COLON) begin
                        n_line_address = '0;
                        n_phase        = PH_ADDR;
                    end else if (i_char == CH_NL) begin
                        n_phase = PH_START;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end
                PH_ADDR, PH_SCAN: begin
                    // a non-hex address character is scanned like any other
                    if (r_phase == PH_ADDR && hex_ok) begin
                        n_line_address = {r_line_address[hrtp_pkg::ADDR_BITS-5:0], hex_val};
                    end else if (i_char == CH_COLON) begin
                        n_byte_count = '0;
                        n_phase      = PH_COUNT;
                    end else if (i_char == CH_NL) begin
                        n_phase = PH_START;
                    end else begin
                        n_phase = PH_SCAN;
                    end
                end
                PH_COUNT: begin
                    if (is_digit) begin
                        if (count_next[CV_W-1:hrtp_pkg::COUNT_BITS] != '0) begin
                            n_phase        = PH_HALT;
                            o_result.valid = 1'b1;
                            o_result.kind  = hrtp_pkg::K_OVERFLOW;
                        end else begin
                            n_byte_count = count_next[hrtp_pkg::COUNT_BITS-1:0];
                        end
                    end else if (i_char == CH_NL) begin
                        n_phase = PH_START;
                    end else if (r_byte_count == '0) begin
                        n_phase = PH_SKIP;
                    end else begin
                        n_phase = PH_FIRST;
                    end
                end
                PH_FIRST, PH_HIGH: begin
                    if (r_phase == PH_FIRST && i_char == CH_NL) begin
                        n_phase = PH_START;
                    end else begin
                        if (r_phase == PH_FIRST) begin
                            if (line_end > r_highest_end) begin
                                n_highest_end = line_end;
                            end
                            n_anything      = 1'b1;
                            n_bytes_left    = r_byte_count;
                            n_write_pointer = r_line_address;
                        end
                        if (!hex_ok) begin
                            n_phase        = PH_HALT;
                            o_result.valid = 1'b1;
                            o_result.kind  = hrtp_pkg::K_BADHEX;
                        end else begin
                            n_high_nibble = hex_val;
                            n_phase       = PH_LOW;
                        end
                    end
                end
                PH_LOW: begin
                    if (!hex_ok) begin
                        n_phase        = PH_HALT;
                        o_result.valid = 1'b1;
                        o_result.kind  = hrtp_pkg::K_BADHEX;
                    end else begin
                        o_result.valid  = 1'b1;
                        o_result.kind   = hrtp_pkg::K_WRITE;
                        o_result.address = wp_used;
                        o_result.data   = {r_high_nibble, hex_val};
                        n_write_pointer = wp_used + ADDR_ONE;
                        n_bytes_left    = left_dec;
                        if (left_dec == '0) begin
                            n_line_address = wp_used + ADDR_ONE;
                            n_phase        = PH_SKIP;
                        end else begin
                            n_phase = PH_HIGH;
                        end
                    end
                end
                PH_SKIP: begin
                    if (i_char == CH_NL) begin
                        n_phase = PH_START;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    // parse state registers, advanced once per processed character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_START;
            r_line_address  <= '0;
            r_byte_count    <= '0;
            r_bytes_left    <= '0;
            r_high_nibble   <= '0;
            r_write_pointer <= '0;
            r_highest_end   <= '0;
            r_anything      <= 1'b0;
        end else if (i_step) begin
            r_phase         <= n_phase;
            r_line_address  <= n_line_address;
            r_byte_count    <= n_byte_count;
            r_bytes_left    <= n_bytes_left;
            r_high_nibble   <= n_high_nibble;
            r_write_pointer <= n_write_pointer;
            r_highest_end   <= n_highest_end;
            r_anything      <= n_anything;
        end
    end

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for hex_record_text_parser_core: directed table, then random records.
// Depends on hrtp_pkg and the parser RTL; results are checked against an in-bench line parser.
`timescale 1ns / 1ps

module tb_top;
    import hrtp_pkg::*;

    localparam int STALL_LIMIT  = 2000;   // cycles with no request moving on either side
    localparam int DRAIN_CYCLES = 10;     // wait for stray results after the expected ones are taken
    localparam int RANDOM_ITEMS = 1120;

    // character codes used by the record format
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_COLON = ":";
    localparam logic [7:0] CH_PLUS  = "+";
    localparam logic [7:0] CH_D     = "D";
    localparam logic [7:0] CH_SPACE = " ";

    // line parser states
    typedef enum logic [3:0] {
        LS_START, LS_GOT_D, LS_ADDR, LS_SCAN, LS_COUNT,
        LS_FIRST, LS_HIGH, LS_LOW, LS_SKIP, LS_HALT
    } line_state_e;

    // one result as it leaves the block
    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic [ADDR_BITS-1:0] addr;
        logic [CHAR_BITS-1:0] data;
        logic [SIZE_BITS-1:0] size;
    } hrec_t;

    // one directed request; typed rows carry their own expectation
    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
        logic       typed;
        logic       has_res;
        hrec_t      res;
    } step_row_t;

    localparam hrec_t NIL_RES = '0;
    localparam int DIRECTED_LEN = 33;

    localparam step_row_t DIRECTED_STEPS [DIRECTED_LEN] = '{
        // end of text straight after reset: empty image
        '{8'h00, 1'b1, 1'b1, 1'b1, '{K_EMPTY, 32'h0, 8'h00, 33'h0}},
        // top address, two bytes wrapping to zero, no newline before the end
        '{CH_D,     1'b0, 1'b0, 1'b0, NIL_RES},
        '{CH_COLON, 1'b0, 1'b0, 1'b0, NIL_RES},
        '{"F",      1'b0, 1'b0, 1'b0, NIL_RES},
        '{"F",      1'b0, 1'b0, 1'b0, NIL_RES},
        '{"F",      1'b0, 1'b0, 1'b0, NIL_RES},
        '{"F",      1'b0, 1'b0, 1'b0, NIL_RES},
        '{"F",      1'b0, 1'b0, 1'b0, NIL_RES},
        '{"F",      1'b0, 1'b0, 1'b0, NIL_RES},
        '{"F",      1'b0, 1'b0, 1'b0, NIL_RES},
        '{"F",      1'b0, 1'b0, 1'b0, NIL_RES},
        '{CH_COLON, 1'b0, 1'b0, 1'b0, NIL_RES},
        '{"2",      1'b0, 1'b0, 1'b0, NIL_RES},
        '{CH_SPACE, 1'b0, 1'b0, 1'b0, NIL_RES},
        '{"f",      1'b0, 1'b0, 1'b0, NIL_RES},
        '{"f",      1'b0, 1'b1, 1'b1, '{K_WRITE, 32'hFFFF_FFFF, 8'hFF, 33'h0}},
        '{"0",      1'b0, 1'b0, 1'b0, NIL_RES},
        '{"0",      1'b0, 1'b1, 1'b1, '{K_WRITE, 32'h0000_0000, 8'h00, 33'h0}},
        // size goes past the 32-bit address range
        '{8'hA5, 1'b1, 1'b1, 1'b1, '{K_DONE, 32'h0, 8'h00, 33'h1_0000_0001}},
        // bad hex on the first data character, then a silent restart
        '{CH_PLUS,  1'b0, 1'b0, 1'b0, NIL_RES},
        '{CH_COLON, 1'b0, 1'b0, 1'b0, NIL_RES},
        '{"1",      1'b0, 1'b0, 1'b0, NIL_RES},
        '{CH_SPACE, 1'b0, 1'b0, 1'b0, NIL_RES},
        '{"g",      1'b0, 1'b1, 1'b1, '{K_BADHEX, 32'h0, 8'h00, 33'h0}},
        '{8'hFF, 1'b1, 1'b1, 1'b0, NIL_RES},
        // count above the 16-bit range
        '{CH_PLUS,  1'b0, 1'b0, 1'b0, NIL_RES},
        '{CH_COLON, 1'b0, 1'b0, 1'b0, NIL_RES},
        '{"9",      1'b0, 1'b0, 1'b0, NIL_RES},
        '{"9",      1'b0, 1'b0, 1'b0, NIL_RES},
        '{"9",      1'b0, 1'b0, 1'b0, NIL_RES},
        '{"9",      1'b0, 1'b0, 1'b0, NIL_RES},
        '{"9",      1'b0, 1'b1, 1'b1, '{K_OVERFLOW, 32'h0, 8'h00, 33'h0}},
        '{8'h5A, 1'b1, 1'b1, 1'b0, NIL_RES}
    };

    // DUT connections
    logic                   clk;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata  = 8'h00;  // [7:0] text_char
    logic                   s_tlast  = 1'b0;   // end_of_text
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;           // [31:0] address, [39:32] data, [72:40] size
    logic [KIND_BITS-1:0]   m_tuser;           // [2:0] kind

    // parser model state
    line_state_e            line_state;
    logic [ADDR_BITS-1:0]   cur_line_addr;
    logic [15:0]            cur_count;
    logic [15:0]            bytes_left;
    logic [3:0]             hi_nib;
    logic [ADDR_BITS-1:0]   wr_ptr;
    logic [SIZE_BITS-1:0]   top_end;
    bit                     any_written;

    hrec_t                  results_q[$];   // parser results still to leave the block
    logic [7:0]             text_q[$];      // characters of the record being sent
    int                     err_count    = 0;
    int                     live_items   = 0;
    int                     seen_results = 0;
    int                     tx_gap_pct   = 0;
    int                     rx_stall_pct = 0;

    hex_record_text_parser_core i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tlast  (s_tlast),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
        v = '0;
        hex_nibble = 1'b1;
        if (c >= "0" && c <= "9") v = 4'(c - "0");
        else if (c >= "a" && c <= "f") v = 4'(c - "a" + 8'd10);
        else if (c >= "A" && c <= "F") v = 4'(c - "A" + 8'd10);
        else hex_nibble = 1'b0;
    endfunction

    // hex digit in either case
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return "0" + v;
        return ($urandom_range(0, 1) ? "a" : "A") + v - 8'd10;
    endfunction

    function automatic void clear_parser();
        line_state    = LS_START;
        cur_line_addr = '0;
        cur_count     = '0;
        bytes_left    = '0;
        hi_nib        = '0;
        wr_ptr        = '0;
        top_end       = '0;
        any_written   = 1'b0;
    endfunction

    // one character through the line parser; returns 1 when it yields a result
    function automatic bit parse_char(input logic [7:0] c, input logic eot, output hrec_t r);
        bit                   is_hex;
        bit                   emitted;
        logic [3:0]           nib;
        logic [19:0]          acc;
        logic [SIZE_BITS-1:0] line_end;
        r       = '0;
        emitted = 1'b0;
        is_hex  = hex_nibble(c, nib);
        if (eot) begin
            // report unless halted, then restart
            if (line_state != LS_HALT) begin
                emitted = 1'b1;
                if (any_written) begin
                    r.kind = K_DONE;
                    r.size = top_end;
                end else begin
                    r.kind = K_EMPTY;
                end
            end
            clear_parser();
        end else begin
            case (line_state)
                LS_START: begin
                    if (c == CH_D) line_state = LS_GOT_D;
                    else if (c == CH_PLUS) line_state = LS_SCAN;
                    else if (c != CH_NL) line_state = LS_SKIP;
                end
                LS_GOT_D: begin
                    if (c == CH_COLON) begin
                        cur_line_addr = '0;
                        line_state    = LS_ADDR;
                    end else if (c == CH_NL) begin
                        line_state = LS_START;
                    end else begin
                        line_state = LS_SKIP;
                    end
                end
                // address digits; the first non-hex character is scanned as usual
                LS_ADDR, LS_SCAN: begin
                    if (line_state == LS_ADDR && is_hex) begin
                        cur_line_addr = {cur_line_addr[ADDR_BITS-5:0], nib};
                    end else if (c == CH_COLON) begin
                        cur_count  = '0;
                        line_state = LS_COUNT;
                    end else if (c == CH_NL) begin
                        line_state = LS_START;
                    end else begin
                        line_state = LS_SCAN;
                    end
                end
                LS_COUNT: begin
                    if (c >= "0" && c <= "9") begin
                        acc = cur_count * 20'd10 + (c - "0");
                        if (acc > 20'hFFFF) begin
                            line_state = LS_HALT;
                            r.kind     = K_OVERFLOW;
                            emitted    = 1'b1;
                        end else begin
                            cur_count = acc[15:0];
                        end
                    end else if (c == CH_NL) begin
                        line_state = LS_START;
                    end else if (cur_count == 0) begin
                        line_state = LS_SKIP;
                    end else begin
                        line_state = LS_FIRST;
                    end
                end
                // first data character opens the line's writes and raises the size
                LS_FIRST, LS_HIGH: begin
                    if (line_state == LS_FIRST && c == CH_NL) begin
                        line_state = LS_START;
                    end else begin
                        if (line_state == LS_FIRST) begin
                            line_end = {1'b0, cur_line_addr} + cur_count;
                            if (line_end > top_end) top_end = line_end;
                            any_written = 1'b1;
                            bytes_left  = cur_count;
                            wr_ptr      = cur_line_addr;
                        end
                        if (!is_hex) begin
                            line_state = LS_HALT;
                            r.kind     = K_BADHEX;
                            emitted    = 1'b1;
                        end else begin
                            hi_nib     = nib;
                            line_state = LS_LOW;
                        end
                    end
                end
                LS_LOW: begin
                    if (!is_hex) begin
                        line_state = LS_HALT;
                        r.kind     = K_BADHEX;
                    end else begin
                        r.kind = K_WRITE;
                        r.addr = wr_ptr;
                        r.data = {hi_nib, nib};
                        wr_ptr = wr_ptr + 1'b1;
                        if (bytes_left != 0) bytes_left = bytes_left - 1'b1;
                        if (bytes_left == 0) begin
                            cur_line_addr = wr_ptr;
                            line_state    = LS_SKIP;
                        end else begin
                            line_state = LS_HIGH;
                        end
                    end
                    emitted = 1'b1;
                end
                LS_SKIP: begin
                    if (c == CH_NL) line_state = LS_START;
                end
                default: ;
            endcase
        end
        return emitted;
    endfunction

    // one request on the input side; called and returns at a falling edge
    task automatic feed(input logic [7:0] ch, input logic eot, input logic typed,
                        input logic has_res, input hrec_t res);
        hrec_t pred;
        bit    got;
        bit    was_halted;
        while ($urandom_range(0, 99) < tx_gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= eot;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        was_halted = (line_state == LS_HALT);
        got = parse_char(ch, eot, pred);
        if (typed) begin
            got  = has_res;
            pred = res;
        end
        if (got) results_q.push_back(pred);
        if (!was_halted || eot) live_items++;
        @(negedge clk);
    endtask

    // fill text_q with one record, a junk line or a burst of noise
    function automatic void build_record(output bit unterminated);
        int         sel;
        int         n;
        int         cnt;
        int         pairs;
        bit         big;
        bit         near_top;
        string      digits;
        logic [7:0] b;
        logic [3:0] nib;
        text_q.delete();
        unterminated = 1'b0;
        sel = $urandom_range(0, 99);
        if (sel >= 90) begin
            repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        if (sel >= 80) begin
            repeat ($urandom_range(0, 12)) begin
                do b = 8'($urandom_range(0, 255)); while (b == CH_NL);
                text_q.push_back(b);
            end
            text_q.push_back(CH_NL);
            return;
        end
        // record head: address line or continuation line
        if (sel < 45) begin
            text_q.push_back(CH_D);
            text_q.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
                                                          : CH_COLON);
            n        = $urandom_range(0, 9);
            near_top = ($urandom_range(0, 5) == 0);
            for (int i = 0; i < n; i++)
                text_q.push_back(hex_char((near_top && i < n - 1) ? 4'hF
                                                                  : 4'($urandom_range(0, 15))));
        end else begin
            text_q.push_back(CH_PLUS);
        end
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range("g", "z")));
        text_q.push_back(CH_COLON);
        // count: missing, zero, overflowing, large, or small
        sel = $urandom_range(0, 99);
        big = 1'b0;
        if (sel < 8) begin
            cnt = 0;
        end else if (sel < 12) begin
            cnt = $urandom_range(65536, 999999);
            big = 1'b1;
        end else if (sel < 16) begin
            cnt = $urandom_range(0, 1) ? 65535 : $urandom_range(9, 65535);
            big = 1'b1;
        end else begin
            cnt = $urandom_range(1, 8);
        end
        if (sel >= 4) begin
            digits = $sformatf("%0d", cnt);
            if ($urandom_range(0, 5) == 0) digits = {"0", digits};
            for (int i = 0; i < digits.len(); i++) text_q.push_back(digits[i]);
        end
        // separator, newline now and then
        if ($urandom_range(0, 19) == 0) begin
            text_q.push_back(CH_NL);
            return;
        end
        do b = 8'($urandom_range(0, 255)); while ((b >= "0" && b <= "9") || b == CH_NL);
        text_q.push_back(b);
        if ($urandom_range(0, 19) == 0) begin
            text_q.push_back(CH_NL);
            return;
        end
        // data pairs; a cut-short line stops at a non-hex character or an early newline
        if (cnt == 0) begin
            pairs = $urandom_range(0, 2);
        end else if (big || $urandom_range(0, 11) == 0) begin
            pairs = $urandom_range(0, (cnt > 4) ? 4 : cnt - 1);
            repeat (2 * pairs) text_q.push_back(hex_char(4'($urandom_range(0, 15))));
            if ($urandom_range(0, 1)) text_q.push_back(hex_char(4'($urandom_range(0, 15))));
            if ($urandom_range(0, 2) == 0) begin
                b = CH_NL;
            end else begin
                do b = 8'($urandom_range(0, 255)); while (hex_nibble(b, nib));
            end
            text_q.push_back(b);
            text_q.push_back(CH_NL);
            return;
        end else begin
            pairs = cnt;
        end
        repeat (2 * pairs) text_q.push_back(hex_char(4'($urandom_range(0, 15))));
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 4)) begin
                do b = 8'($urandom_range(0, 255)); while (b == CH_NL);
                text_q.push_back(b);
            end
        end
        if ($urandom_range(0, 19) == 0) unterminated = 1'b1;
        else text_q.push_back(CH_NL);
    endfunction

    function automatic void flag_error(input string msg);
        err_count++;
        if (err_count <= 10) $display("%s", msg);
    endfunction

    // receiver back-pressure
    initial begin
        forever begin
            @(negedge clk);
            m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // result checker
    always @(posedge clk) begin : result_check
        hrec_t got;
        hrec_t want;
        if (rst_n && m_tvalid && m_tready) begin
            got.kind = m_tuser;
            got.addr = m_tdata[ADDR_BITS-1:0];
            got.data = m_tdata[ADDR_BITS +: CHAR_BITS];
            got.size = m_tdata[ADDR_BITS+CHAR_BITS +: SIZE_BITS];
            if (results_q.size() == 0) begin
                flag_error($sformatf("result %0d unexpected: kind %0d addr %h data %h size %h",
                                     seen_results, got.kind, got.addr, got.data, got.size));
            end else begin
                want = results_q.pop_front();
                if (got !== want)
                    flag_error($sformatf({"result %0d mismatch: kind %0d/%0d addr %h/%h ",
                                          "data %h/%h size %h/%h (expected/actual)"},
                                         seen_results, want.kind, got.kind, want.addr,
                                         got.addr, want.data, got.data, want.size, got.size));
            end
            seen_results++;
        end
    end

    // watchdog: ends the run when no request moves for too long
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("tb_top: FAIL");
        $finish;
    end

    // stimulus and end of run
    initial begin : stimulus
        int         idle_phase;
        int         random_start;
        bit         unterminated;
        step_row_t  row;
        clear_parser();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int i = 0; i < DIRECTED_LEN; i++) begin
            row = DIRECTED_STEPS[i];
            feed(row.ch, row.eot, row.typed, row.has_res, row.res);
        end

        // random records across four idling phases
        random_start = live_items;
        while (live_items - random_start < RANDOM_ITEMS) begin
            idle_phase = (live_items - random_start) * 4 / RANDOM_ITEMS;
            case (idle_phase)
                0:       begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_gap_pct = 46; rx_stall_pct = 0;  end
                2:       begin tx_gap_pct = 0;  rx_stall_pct = 46; end
                default: begin tx_gap_pct = 30; rx_stall_pct = 30; end
            endcase
            if (line_state == LS_HALT) begin
                // halted: some ignored text, then the restarting end of text
                if ($urandom_range(0, 1))
                    repeat ($urandom_range(1, 4))
                        feed(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, NIL_RES);
                feed(8'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b0, NIL_RES);
            end else if ($urandom_range(0, 15) == 0) begin
                feed(8'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b0, NIL_RES);
            end else begin
                build_record(unterminated);
                while (text_q.size() != 0)
                    feed(text_q.pop_front(), 1'b0, 1'b0, 1'b0, NIL_RES);
                if (unterminated) feed(8'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b0, NIL_RES);
            end
        end
        s_tvalid <= 1'b0;

        // drain outstanding results, then watch for strays
        while (results_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0 && results_q.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
